[rtl/lcru_pkg.sv]
// shared constants, types and command codes of the lattice coefficient rounding unit
package lcru_pkg;

    // arithmetic constants
    localparam int unsigned MODULUS   = 8380417;
    localparam int unsigned HALF_STEP = 261888;
    localparam int unsigned DROP_BITS = 13;
    localparam int unsigned HIGH_MAX  = 15;
    localparam int unsigned STEP      = 2 * HALF_STEP;

    // reduced coefficient width, modulus stays below 2^30
    localparam int unsigned REM_W = 30;

    // barrett reciprocals and the offset that re-centers a signed coefficient
    localparam logic [31:0]      RECIP_MOD  = 32'((64'd1 << 32) / 64'(MODULUS));
    localparam logic [REM_W-1:0] RECIP_STEP = REM_W'((64'd1 << 30) / 64'(STEP));
    localparam logic [REM_W-1:0] OFFSET_MOD = REM_W'((64'd1 << 31) % 64'(MODULUS));
    localparam logic [REM_W-1:0] MOD_MINUS_OFS = REM_W'(MODULUS) - OFFSET_MOD;

    localparam logic [REM_W-1:0]     MOD_R      = REM_W'(MODULUS);
    localparam logic [REM_W:0]       MOD_T      = (REM_W + 1)'(MODULUS);
    localparam logic [REM_W:0]       STEP_T     = (REM_W + 1)'(STEP);
    localparam logic [REM_W:0]       HALF_T     = (REM_W + 1)'(HALF_STEP);
    localparam logic [REM_W:0]       STEP_HALF_T = (REM_W + 1)'(STEP + HALF_STEP);
    localparam logic [31:0]          STEP_32    = 32'(STEP);
    localparam logic [31:0]          STEP2_32   = 32'(2 * STEP);
    localparam logic signed [31:0]   HALF_S     = 32'(HALF_STEP);
    localparam logic signed [31:0]   HINT_HI_S  = 32'(MODULUS - HALF_STEP);
    localparam logic [31:0]          HIGH_MAX_32 = 32'(HIGH_MAX);
    localparam logic signed [32:0]   MOD_M1_S   = 33'(MODULUS - 1);
    localparam logic signed [32:0]   P2R_BIAS   = 33'((64'd1 << (DROP_BITS - 1)) - 64'd1);

    // command codes
    localparam logic [1:0] CMD_P2R     = 2'd0;
    localparam logic [1:0] CMD_DECOMP  = 2'd1;
    localparam logic [1:0] CMD_MKHINT  = 2'd2;
    localparam logic [1:0] CMD_USEHINT = 2'd3;

    // data that rides along the pipeline next to the decompose path
    typedef struct packed {
        logic [1:0]         cmd;
        logic               hint;
        logic signed [31:0] hi;
        logic signed [31:0] lo;
    } t_side;

    // decompose result before the corner fold
    typedef struct packed {
        logic [REM_W:0]     hi;
        logic signed [31:0] lo;
        logic [REM_W-1:0]   rem;
    } t_split;

endpackage

[rtl/lcru_decomp.sv]
// six-stage modular reduction and centered split of a signed coefficient
module lcru_decomp (
    input  logic                i_clk,
    input  logic [5:0]          i_stage_en,
    input  logic signed [31:0]  i_coef,
    output lcru_pkg::t_split    o_split
);

    // stage 1: offset to unsigned, barrett quotient estimate
    logic [31:0]                    n_x;
    logic [63:0]                    n_prod1;
    logic [31:0]                    r_x;
    logic [31:0]                    r_qh1;
    // stage 2: first remainder in [0, 2q)
    logic [63:0]                    n_prod2;
    logic [lcru_pkg::REM_W:0]       n_t;
    logic [lcru_pkg::REM_W:0]       r_t;
    // stage 3: reduced value in [0, q)
    logic [lcru_pkg::REM_W-1:0]     n_r0;
    logic [lcru_pkg::REM_W-1:0]     n_rem3;
    logic [lcru_pkg::REM_W-1:0]     r_rem3;
    // stage 4: quotient estimate by the split step
    logic [59:0]                    n_prod3;
    logic [lcru_pkg::REM_W-1:0]     r_rem4;
    logic [lcru_pkg::REM_W-1:0]     r_q4;
    // stage 5: raw low part in [0, 2*step)
    logic [59:0]                    n_prod4;
    logic [59:0]                    n_diff5;
    logic [lcru_pkg::REM_W-1:0]     r_rem5;
    logic [lcru_pkg::REM_W-1:0]     r_q5;
    logic [lcru_pkg::REM_W:0]       r_lo5;
    // stage 6: corrected and centered
    lcru_pkg::t_split               n_split;
    lcru_pkg::t_split               r_split;

    assign n_x     = {~i_coef[31], i_coef[30:0]};
    assign n_prod1 = 64'(n_x) * 64'(lcru_pkg::RECIP_MOD);

    always_ff @(posedge i_clk) begin
        if (i_stage_en[0]) begin
            r_x   <= n_x;
            r_qh1 <= n_prod1[63:32];
        end
    end

    assign n_prod2 = 64'(r_qh1) * 64'(lcru_pkg::MODULUS);
    assign n_t     = (lcru_pkg::REM_W + 1)'(64'(r_x) - n_prod2);

    always_ff @(posedge i_clk) begin
        if (i_stage_en[1]) begin
            r_t <= n_t;
        end
    end

    // one conditional subtract, then remove the offset mod q
    always_comb begin
        if (r_t >= lcru_pkg::MOD_T) begin
            n_r0 = lcru_pkg::REM_W'(r_t - lcru_pkg::MOD_T);
        end else begin
            n_r0 = r_t[lcru_pkg::REM_W-1:0];
        end
        if (n_r0 >= lcru_pkg::OFFSET_MOD) begin
            n_rem3 = n_r0 - lcru_pkg::OFFSET_MOD;
        end else begin
            n_rem3 = n_r0 + lcru_pkg::MOD_MINUS_OFS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_stage_en[2]) begin
            r_rem3 <= n_rem3;
        end
    end

    assign n_prod3 = 60'(r_rem3) * 60'(lcru_pkg::RECIP_STEP);

    always_ff @(posedge i_clk) begin
        if (i_stage_en[3]) begin
            r_rem4 <= r_rem3;
            r_q4   <= n_prod3[59:30];
        end
    end

    assign n_prod4 = 60'(r_q4) * 60'(lcru_pkg::STEP);
    assign n_diff5 = 60'(r_rem4) - n_prod4;

    always_ff @(posedge i_clk) begin
        if (i_stage_en[4]) begin
            r_rem5 <= r_rem4;
            r_q5   <= r_q4;
            r_lo5  <= n_diff5[lcru_pkg::REM_W:0];
        end
    end

    // fold the estimate error and the centering into one three-way choice
    always_comb begin
        n_split.rem = r_rem5;
        if (r_lo5 <= lcru_pkg::HALF_T) begin
            n_split.hi = (lcru_pkg::REM_W + 1)'(r_q5);
            n_split.lo = 32'(r_lo5);
        end else if (r_lo5 <= lcru_pkg::STEP_HALF_T) begin
            n_split.hi = (lcru_pkg::REM_W + 1)'(r_q5) + 1'b1;
            n_split.lo = 32'(r_lo5) - lcru_pkg::STEP_32;
        end else begin
            n_split.hi = (lcru_pkg::REM_W + 1)'(r_q5) + 2'd2;
            n_split.lo = 32'(r_lo5) - lcru_pkg::STEP2_32;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_stage_en[5]) begin
            r_split <= n_split;
        end
    end

    assign o_split = r_split;

endmodule

[rtl/lattice_coefficient_rounding_unit.sv]
// top level of the lattice coefficient rounding unit
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  request  | in        | i_valid / o_ready  | i_cmd, i_coef, i_other_high, i_hint_bit
//  result   | out       | o_valid / i_ready  | o_high_part, o_low_part
//
// one request per cycle sustained while the result side accepts; each request gives exactly one result
// stage one loads at accept; stages two to six and the output register behind o_valid follow
// the stage depth is set by the two barrett multiply chains of the decompose path
// reset (i_rst_n low at a clock edge) clears every stage valid bit and the output valid
// a stalled result only holds stages that carry a request; empty stages keep filling,
// so a held output does not block o_ready until the whole pipeline is occupied
module lattice_coefficient_rounding_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_cmd,
    input  logic signed [31:0] i_coef,
    input  logic signed [31:0] i_other_high,
    input  logic               i_hint_bit,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_high_part,
    output logic signed [31:0] o_low_part
);

    // per-stage advance enables, bubbles collapse toward the output
    logic [5:0]             w_en;
    logic                   w_en_out;
    logic [5:0]             r_valid;
    lcru_pkg::t_side        r_side [0:5];
    lcru_pkg::t_side        n_side;

    // power2round and hint generation work directly on the request
    logic signed [32:0]     n_p2r_sum;

    // decompose path result from stage 6
    lcru_pkg::t_split       w_split;

    // final stage: corner fold, hint step and command select
    logic signed [32:0]     n_diff;
    logic                   n_corner;
    logic [31:0]            n_dec_hi;
    logic signed [31:0]     n_dec_lo;
    logic [31:0]            n_use_hi;
    logic signed [31:0]     n_out_hi;
    logic signed [31:0]     n_out_lo;
    logic                   r_out_valid;
    logic signed [31:0]     r_out_hi;
    logic signed [31:0]     r_out_lo;

    // stall chain: a stage moves when it is empty or the next one moves
    always_comb begin
        w_en_out = !r_out_valid || i_ready;
        w_en[5]  = !r_valid[5] || w_en_out;
        for (int k = 4; k >= 0; k--) begin
            w_en[k] = !r_valid[k] || w_en[k+1];
        end
    end

    assign o_ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_en[0]) begin
                r_valid[0] <= i_valid;
            end
            for (int k = 1; k < 6; k++) begin
                if (w_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // power2round: floor((a + 2^(d-1) - 1) / 2^d), remainder re-biased
    assign n_p2r_sum = $signed({i_coef[31], i_coef}) + lcru_pkg::P2R_BIAS;

    always_comb begin
        n_side.cmd  = i_cmd;
        n_side.hint = i_hint_bit;
        n_side.hi   = '0;
        n_side.lo   = '0;
        case (i_cmd)
            lcru_pkg::CMD_P2R: begin
                n_side.hi = 32'(n_p2r_sum >>> lcru_pkg::DROP_BITS);
                n_side.lo = 32'(n_p2r_sum[lcru_pkg::DROP_BITS-1:0])
                            - 32'(lcru_pkg::P2R_BIAS);
            end
            lcru_pkg::CMD_MKHINT: begin
                // hint set only strictly inside the band, upper edge needs a nonzero high part
                if (i_coef <= lcru_pkg::HALF_S || i_coef > lcru_pkg::HINT_HI_S
                    || (i_coef == lcru_pkg::HINT_HI_S && i_other_high == '0)) begin
                    n_side.hi = '0;
                end else begin
                    n_side.hi = 32'sd1;
                end
            end
            default: begin
                n_side.hi = '0;
                n_side.lo = '0;
            end
        endcase
    end

    // side data follows the valid bits stage for stage
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_side[0] <= n_side;
        end
        for (int k = 1; k < 6; k++) begin
            if (w_en[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    lcru_decomp u_decomp (
        .i_clk      (i_clk),
        .i_stage_en (w_en),
        .i_coef     (i_coef),
        .o_split    (w_split)
    );

    // top corner: reduced value minus low part equal to q-1 folds to high part 0
    assign n_diff   = $signed({3'b000, w_split.rem}) - $signed({w_split.lo[31], w_split.lo});
    assign n_corner = (n_diff == lcru_pkg::MOD_M1_S);
    assign n_dec_hi = n_corner ? '0 : 32'(w_split.hi);
    assign n_dec_lo = n_corner ? (w_split.lo - 32'sd1) : w_split.lo;

    // hint step with wrap between 0 and the top high value
    always_comb begin
        n_use_hi = n_dec_hi;
        if (r_side[5].hint) begin
            if (n_dec_lo > 32'sd0) begin
                n_use_hi = (n_dec_hi == lcru_pkg::HIGH_MAX_32) ? '0 : n_dec_hi + 32'd1;
            end else begin
                n_use_hi = (n_dec_hi == '0) ? lcru_pkg::HIGH_MAX_32 : n_dec_hi - 32'd1;
            end
        end
    end

    always_comb begin
        case (r_side[5].cmd)
            lcru_pkg::CMD_DECOMP: begin
                n_out_hi = n_dec_hi;
                n_out_lo = n_dec_lo;
            end
            lcru_pkg::CMD_USEHINT: begin
                n_out_hi = n_use_hi;
                n_out_lo = '0;
            end
            default: begin
                n_out_hi = r_side[5].hi;
                n_out_lo = r_side[5].lo;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en_out) begin
            r_out_valid <= r_valid[5];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_out) begin
            r_out_hi <= n_out_hi;
            r_out_lo <= n_out_lo;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_high_part = r_out_hi;
    assign o_low_part  = r_out_lo;

    // request side can only be blocked when every stage and the output are occupied
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_valid == 6'h3f) && o_valid && !i_ready)
        else $error("request blocked while the pipeline has room");

    // barrett correction must leave a centered low part
    a_low_centered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[5] |-> (w_split.lo > -lcru_pkg::HALF_S) && (w_split.lo <= lcru_pkg::HALF_S))
        else $error("decompose low part outside the centered range");

    // modular reduction must land below the modulus
    a_rem_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[5] |-> (w_split.rem < lcru_pkg::MOD_R))
        else $error("reduced coefficient not below the modulus");

endmodule
